// ===== rtl/core/framed_command_packet_parser_core_assert.svh =====
// Assertion macros for the framed command packet parser checkers.
// Depends on nothing; included by the checker module.
`ifndef FRAMED_COMMAND_PACKET_PARSER_CORE_ASSERT_SVH
`define FRAMED_COMMAND_PACKET_PARSER_CORE_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define FCPP_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define FCPP_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/fcpp_pkg.sv =====
// Shared types and constants of the framed command packet parser.
// No dependencies; imported by every RTL module of the block.
`default_nettype none

package fcpp_pkg;

    localparam int MAX_PAYLOAD_DEF = 64;
    localparam int CFG_IDX_W       = 2;
    localparam int IDX_W           = 6;
    localparam int LEN_W           = 7;

    localparam logic [CFG_IDX_W-1:0] CFG_HEADER_FIRST  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HEADER_SECOND = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FOOTER_BYTE   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CHECK_BYTE    = 2'd3;

    localparam logic [7:0] HEADER_FIRST_RST  = 8'd170;
    localparam logic [7:0] HEADER_SECOND_RST = 8'd85;
    localparam logic [7:0] FOOTER_BYTE_RST   = 8'd13;
    localparam logic [7:0] CHECK_BYTE_RST    = 8'd0;

    typedef enum logic [2:0] {
        PH_HEADER1,
        PH_HEADER2,
        PH_COMMAND,
        PH_LENGTH,
        PH_DATA,
        PH_CHECK,
        PH_FOOTER
    } t_phase;

    typedef enum logic [1:0] {
        ST_INCOMPLETE,
        ST_VALID,
        ST_INVALID
    } t_status;

    typedef struct packed {
        logic [7:0] header_first;
        logic [7:0] header_second;
        logic [7:0] footer_byte;
        logic [7:0] check_byte;
    } t_cfg;

    typedef struct packed {
        t_status          status;
        logic [7:0]       frame_command;
        logic             payload_write;
        logic [IDX_W-1:0] payload_index;
        logic [7:0]       payload_byte;
        logic [LEN_W-1:0] payload_length;
    } t_result;

endpackage

`default_nettype wire

// ===== rtl/core/fcpp_in_if.sv =====
// Byte request channel of the framed command packet parser.
// No dependencies.
`default_nettype none

interface fcpp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;

    modport source (output valid, output in_byte, input ready);
    modport sink   (input valid, input in_byte, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/fcpp_out_if.sv =====
// Result channel of the framed command packet parser.
// No dependencies; field widths follow fcpp_pkg.
`default_nettype none

interface fcpp_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] status;
    logic [7:0] frame_command;
    logic       payload_write;
    logic [5:0] payload_index;
    logic [7:0] payload_byte;
    logic [6:0] payload_length;

    modport source (output valid, output status, output frame_command,
                    output payload_write, output payload_index,
                    output payload_byte, output payload_length, input ready);
    modport sink   (input valid, input status, input frame_command,
                    input payload_write, input payload_index,
                    input payload_byte, input payload_length, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/fcpp_step.sv =====
// Frame walker: next parser state and result for one received byte.
// Depends on fcpp_pkg.
`default_nettype none

module fcpp_step #(
    parameter int MAX_PAYLOAD = fcpp_pkg::MAX_PAYLOAD_DEF,
    parameter int CNT_W       = $clog2(MAX_PAYLOAD + 1)
) (
    input  fcpp_pkg::t_cfg    i_cfg,
    input  fcpp_pkg::t_phase  i_phase,
    input  logic [7:0]        i_held_command,
    input  logic [CNT_W-1:0]  i_exp_len,
    input  logic [CNT_W-1:0]  i_taken,
    input  logic [7:0]        i_byte,
    output fcpp_pkg::t_phase  o_phase,
    output logic [7:0]        o_held_command,
    output logic [CNT_W-1:0]  o_exp_len,
    output logic [CNT_W-1:0]  o_taken,
    output fcpp_pkg::t_result o_res
);
    import fcpp_pkg::*;

    logic [CNT_W-1:0] taken_inc;
    logic             len_too_big;

    assign taken_inc   = i_taken + CNT_W'(1);
    // L+1 > MAX  <=>  L >= MAX
    assign len_too_big = {1'b0, i_byte} >= 9'(MAX_PAYLOAD);

    always_comb begin
        logic restart;
        restart                = 1'b0;
        o_phase                = i_phase;
        o_held_command         = i_held_command;
        o_exp_len              = i_exp_len;
        o_taken                = i_taken;
        o_res.status           = ST_INCOMPLETE;
        o_res.frame_command    = '0;
        o_res.payload_write    = 1'b0;
        o_res.payload_index    = '0;
        o_res.payload_byte     = '0;

        unique case (i_phase)
            PH_HEADER1: begin
                if (i_byte == i_cfg.header_first) o_phase = PH_HEADER2;
            end
            PH_HEADER2: begin
                if (i_byte == i_cfg.header_second) begin
                    o_phase = PH_COMMAND;
                end else begin
                    restart      = 1'b1;
                    o_res.status = ST_INVALID;
                end
            end
            PH_COMMAND: begin
                o_held_command = i_byte;
                o_phase        = PH_LENGTH;
            end
            PH_LENGTH: begin
                if (i_byte == 8'd0) begin
                    o_phase = PH_CHECK;
                end else if (len_too_big) begin
                    restart      = 1'b1;
                    o_res.status = ST_INVALID;
                end else begin
                    o_taken   = '0;
                    o_exp_len = CNT_W'({1'b0, i_byte} + 9'd1);
                    o_phase   = PH_DATA;
                end
            end
            PH_DATA: begin
                o_res.payload_write = 1'b1;
                o_res.payload_index = IDX_W'(i_taken);
                o_res.payload_byte  = i_byte;
                o_taken             = taken_inc;
                if (taken_inc >= i_exp_len) begin
                    if (i_byte == i_cfg.check_byte) begin
                        o_phase = PH_FOOTER;
                    end else begin
                        restart      = 1'b1;
                        o_res.status = ST_INVALID;
                    end
                end else if (i_byte == i_cfg.footer_byte) begin
                    // early footer: byte still goes out, frame dropped
                    restart      = 1'b1;
                    o_res.status = ST_INVALID;
                end
            end
            PH_CHECK: begin
                if (i_byte == i_cfg.check_byte) begin
                    o_phase = PH_FOOTER;
                end else begin
                    restart      = 1'b1;
                    o_res.status = ST_INVALID;
                end
            end
            PH_FOOTER: begin
                restart = 1'b1;
                if (i_byte == i_cfg.footer_byte) begin
                    o_res.status        = ST_VALID;
                    o_res.frame_command = i_held_command;
                end else begin
                    o_res.status = ST_INVALID;
                end
            end
            default: begin
                restart      = 1'b1;
                o_res.status = ST_INVALID;
            end
        endcase

        if (restart) begin
            o_phase   = PH_HEADER1;
            o_exp_len = '0;
            o_taken   = '0;
        end
        o_res.payload_length = LEN_W'(o_exp_len);
    end

endmodule

`default_nettype wire

// ===== rtl/core/fcpp_out_buf.sv =====
// Two-entry result buffer (output register plus skid stage).
// Depends on fcpp_pkg.
`default_nettype none

module fcpp_out_buf (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  fcpp_pkg::t_result i_res,
    output logic              o_space,
    output logic              o_valid,
    input  logic              i_ready,
    output fcpp_pkg::t_result o_res
);
    import fcpp_pkg::*;

    logic    r_main_valid, n_main_valid;
    logic    r_skid_valid, n_skid_valid;
    t_result r_main, n_main;
    t_result r_skid, n_skid;
    logic    pop;

    assign o_space = !r_skid_valid;
    assign o_valid = r_main_valid;
    assign o_res   = r_main;
    assign pop     = r_main_valid && i_ready;

    always_comb begin
        n_main_valid = r_main_valid;
        n_skid_valid = r_skid_valid;
        n_main       = r_main;
        n_skid       = r_skid;
        if (pop || !r_main_valid) begin
            if (r_skid_valid) begin
                n_main       = r_skid;
                n_main_valid = 1'b1;
                n_skid_valid = 1'b0;
            end else begin
                n_main       = i_res;
                n_main_valid = i_push;
            end
        end else if (i_push) begin
            n_skid       = i_res;
            n_skid_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_main_valid <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_main_valid <= n_main_valid;
            r_skid_valid <= n_skid_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_main <= n_main;
        r_skid <= n_skid;
    end

endmodule

`default_nettype wire

// ===== rtl/core/framed_command_packet_parser_core.sv =====
// Framed command packet parser. Walks received bytes through a frame of
// header1, header2, command, length L, then L+1 payload bytes (the last one
// must equal the check byte) or, for L = 0, a separate check byte, and a
// footer. Each request returns exactly one result: a status (incomplete,
// valid, invalid), the command on a valid frame, and for payload bytes the
// byte with its index, plus the current payload length. Throughput is one
// request per cycle while the output buffer has room: the whole frame
// step is a single compare-and-count pass between the parser state
// registers and the result register. A two-entry output buffer
// lets one more request in while a result waits; the byte channel stalls
// only when both entries are full. Configuration writes land at the clock
// edge with i_cfg_we high and must happen while the block is idle.
// Depends on fcpp_pkg, fcpp_in_if, fcpp_out_if, fcpp_step, fcpp_out_buf.
`default_nettype none

module framed_command_packet_parser_core #(
    parameter int MAX_PAYLOAD = fcpp_pkg::MAX_PAYLOAD_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [fcpp_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [7:0]                     i_cfg_data,
    fcpp_in_if.sink                        i_req,
    fcpp_out_if.source                     o_res
);
    import fcpp_pkg::*;

    // counters must hold MAX_PAYLOAD itself
    localparam int CNT_W = $clog2(MAX_PAYLOAD + 1);

    // configuration registers
    t_cfg r_cfg;

    // parser state
    t_phase           r_phase, n_phase;
    logic [7:0]       r_held_command, n_held_command;
    logic [CNT_W-1:0] r_exp_len, n_exp_len;
    logic [CNT_W-1:0] r_taken, n_taken;

    t_result step_res;
    t_result buf_res;
    logic    accept;
    logic    space;

    assign i_req.ready = space;
    assign accept      = i_req.valid && space;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.header_first  <= HEADER_FIRST_RST;
            r_cfg.header_second <= HEADER_SECOND_RST;
            r_cfg.footer_byte   <= FOOTER_BYTE_RST;
            r_cfg.check_byte    <= CHECK_BYTE_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_HEADER_FIRST:  r_cfg.header_first  <= i_cfg_data;
                CFG_HEADER_SECOND: r_cfg.header_second <= i_cfg_data;
                CFG_FOOTER_BYTE:   r_cfg.footer_byte   <= i_cfg_data;
                CFG_CHECK_BYTE:    r_cfg.check_byte    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // single-pass frame step on the incoming byte
    fcpp_step #(
        .MAX_PAYLOAD (MAX_PAYLOAD),
        .CNT_W       (CNT_W)
    ) u_step (
        .i_cfg          (r_cfg),
        .i_phase        (r_phase),
        .i_held_command (r_held_command),
        .i_exp_len      (r_exp_len),
        .i_taken        (r_taken),
        .i_byte         (i_req.in_byte),
        .o_phase        (n_phase),
        .o_held_command (n_held_command),
        .o_exp_len      (n_exp_len),
        .o_taken        (n_taken),
        .o_res          (step_res)
    );

    // state advances only on an accepted request
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase        <= PH_HEADER1;
            r_held_command <= '0;
            r_exp_len      <= '0;
            r_taken        <= '0;
        end else if (accept) begin
            r_phase        <= n_phase;
            r_held_command <= n_held_command;
            r_exp_len      <= n_exp_len;
            r_taken        <= n_taken;
        end
    end

    fcpp_out_buf u_out_buf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (accept),
        .i_res   (step_res),
        .o_space (space),
        .o_valid (o_res.valid),
        .i_ready (o_res.ready),
        .o_res   (buf_res)
    );

    assign o_res.status         = buf_res.status;
    assign o_res.frame_command  = buf_res.frame_command;
    assign o_res.payload_write  = buf_res.payload_write;
    assign o_res.payload_index  = buf_res.payload_index;
    assign o_res.payload_byte   = buf_res.payload_byte;
    assign o_res.payload_length = buf_res.payload_length;

endmodule

`default_nettype wire

// ===== rtl/core/fcpp_checker.sv =====
// Port-level checker for the framed command packet parser, with its bind.
// Depends on fcpp_pkg and framed_command_packet_parser_core_assert.svh.
`default_nettype none

`include "framed_command_packet_parser_core_assert.svh"

module fcpp_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic [1:0] i_status,
    input logic [7:0] i_frame_command,
    input logic       i_payload_write,
    input logic [5:0] i_payload_index,
    input logic [7:0] i_payload_byte
);
    import fcpp_pkg::*;

    `FCPP_ASSERT_IMP(a_status_code, i_clk, i_rst_n, i_out_valid, i_status != 2'd3, "bad status code")
    `FCPP_ASSERT_IMP(a_cmd_only_valid, i_clk, i_rst_n, i_out_valid && i_status != ST_VALID, i_frame_command == 8'd0, "command without valid frame")
    `FCPP_ASSERT_IMP(a_payload_quiet, i_clk, i_rst_n, i_out_valid && !i_payload_write, i_payload_index == 6'd0 && i_payload_byte == 8'd0, "payload fields set without write")
    `FCPP_ASSERT_NXT(a_stall_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid && $stable(i_status) && $stable(i_payload_byte), "stalled result changed")

endmodule

bind framed_command_packet_parser_core fcpp_checker u_fcpp_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_out_valid     (o_res.valid),
    .i_out_ready     (o_res.ready),
    .i_status        (o_res.status),
    .i_frame_command (o_res.frame_command),
    .i_payload_write (o_res.payload_write),
    .i_payload_index (o_res.payload_index),
    .i_payload_byte  (o_res.payload_byte)
);

`default_nettype wire

// ===== tb/fcpp_result_checker.sv =====
// Result checker for the framed command packet parser: mirrors the config
// port, walks each accepted byte through a frame model and compares results.
// Depends on fcpp_pkg, fcpp_in_if and fcpp_out_if.
module fcpp_result_checker #(
    parameter int MAX_PAYLOAD = fcpp_pkg::MAX_PAYLOAD_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [fcpp_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [7:0]                     i_cfg_data,
    fcpp_in_if                             i_req_mon,
    fcpp_out_if                            i_res_mon,
    output int                             o_fail_count,
    output int                             o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    import fcpp_pkg::*;

    t_cfg             frame_regs;
    t_phase           walk_phase;
    logic [7:0]       cmd_hold;
    logic [LEN_W-1:0] len_expected;
    logic [LEN_W-1:0] len_seen;
    t_result          frame_results_q[$];

    function automatic void walk_restart();
        walk_phase   = PH_HEADER1;
        len_expected = '0;
        len_seen     = '0;
    endfunction

    // Advances the frame walk by one byte and returns the result it yields.
    function automatic t_result walk_byte(input logic [7:0] b);
        t_result r;
        r = '0;
        r.status = ST_INCOMPLETE;
        case (walk_phase)
            PH_HEADER1: begin
                if (b == frame_regs.header_first) walk_phase = PH_HEADER2;
            end
            PH_HEADER2: begin
                if (b == frame_regs.header_second) begin
                    walk_phase = PH_COMMAND;
                end else begin
                    walk_restart();
                    r.status = ST_INVALID;
                end
            end
            PH_COMMAND: begin
                cmd_hold   = b;
                walk_phase = PH_LENGTH;
            end
            PH_LENGTH: begin
                if (b == 8'd0) begin
                    walk_phase = PH_CHECK;
                end else if (int'(b) + 1 > MAX_PAYLOAD) begin
                    walk_restart();
                    r.status = ST_INVALID;
                end else begin
                    len_seen     = '0;
                    len_expected = LEN_W'(int'(b) + 1);
                    walk_phase   = PH_DATA;
                end
            end
            PH_DATA: begin
                r.payload_write = 1'b1;
                r.payload_index = len_seen[IDX_W-1:0];
                r.payload_byte  = b;
                len_seen        = len_seen + 1'b1;
                if (len_seen >= len_expected) begin
                    if (b == frame_regs.check_byte) begin
                        walk_phase = PH_FOOTER;
                    end else begin
                        walk_restart();
                        r.status = ST_INVALID;
                    end
                end else if (b == frame_regs.footer_byte) begin
                    walk_restart();
                    r.status = ST_INVALID;
                end
            end
            PH_CHECK: begin
                if (b == frame_regs.check_byte) begin
                    walk_phase = PH_FOOTER;
                end else begin
                    walk_restart();
                    r.status = ST_INVALID;
                end
            end
            PH_FOOTER: begin
                if (b == frame_regs.footer_byte) begin
                    r.status        = ST_VALID;
                    r.frame_command = cmd_hold;
                end else begin
                    r.status = ST_INVALID;
                end
                walk_restart();
            end
            default: begin
                walk_restart();
                r.status = ST_INVALID;
            end
        endcase
        r.payload_length = len_expected;
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_result want;
        if (!i_rst_n) begin
            frame_regs.header_first  = HEADER_FIRST_RST;
            frame_regs.header_second = HEADER_SECOND_RST;
            frame_regs.footer_byte   = FOOTER_BYTE_RST;
            frame_regs.check_byte    = CHECK_BYTE_RST;
            cmd_hold                 = 8'd0;
            walk_restart();
            frame_results_q.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_HEADER_FIRST:  frame_regs.header_first  = i_cfg_data;
                    CFG_HEADER_SECOND: frame_regs.header_second = i_cfg_data;
                    CFG_FOOTER_BYTE:   frame_regs.footer_byte   = i_cfg_data;
                    CFG_CHECK_BYTE:    frame_regs.check_byte    = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_req_mon.valid && i_req_mon.ready) begin
                frame_results_q.push_back(walk_byte(i_req_mon.in_byte));
            end
            if (i_res_mon.valid && i_res_mon.ready) begin
                if (frame_results_q.size() == 0) begin
                    $error("result with no request outstanding");
                    o_fail_count++;
                end else begin
                    want = frame_results_q.pop_front();
                    if (i_res_mon.status !== want.status) begin
                        $error("status: expected %0d, got %0d",
                               want.status, i_res_mon.status);
                        o_fail_count++;
                    end
                    if (i_res_mon.frame_command !== want.frame_command) begin
                        $error("frame_command: expected %0d, got %0d",
                               want.frame_command, i_res_mon.frame_command);
                        o_fail_count++;
                    end
                    if (i_res_mon.payload_write !== want.payload_write) begin
                        $error("payload_write: expected %0d, got %0d",
                               want.payload_write, i_res_mon.payload_write);
                        o_fail_count++;
                    end
                    if (i_res_mon.payload_index !== want.payload_index) begin
                        $error("payload_index: expected %0d, got %0d",
                               want.payload_index, i_res_mon.payload_index);
                        o_fail_count++;
                    end
                    if (i_res_mon.payload_byte !== want.payload_byte) begin
                        $error("payload_byte: expected %0d, got %0d",
                               want.payload_byte, i_res_mon.payload_byte);
                        o_fail_count++;
                    end
                    if (i_res_mon.payload_length !== want.payload_length) begin
                        $error("payload_length: expected %0d, got %0d",
                               want.payload_length, i_res_mon.payload_length);
                        o_fail_count++;
                    end
                end
            end
        end
        o_pending = frame_results_q.size();
    end

endmodule

// ===== tb/tb_framed_command_packet_parser_core.sv =====
// Top of the framed command packet parser testbench: clock, reset, config
// writes and byte stimulus, with fcpp_result_checker comparing the results.
// Depends on fcpp_pkg, fcpp_in_if, fcpp_out_if and the parser RTL.
module tb_framed_command_packet_parser_core;
    timeunit 1ns;
    timeprecision 1ps;

    import fcpp_pkg::*;

    localparam int MAX_PAYLOAD  = MAX_PAYLOAD_DEF;
    localparam int PHASE_BYTES  = 350;     // random requests per idling phase
    localparam int HOLD_CYCLES  = 300;     // long receiver hold-off
    localparam int CYCLE_LIMIT  = 400000;  // watchdog, far above a slow run
    localparam int DRAIN_CYCLES = 4;       // quiet cycles after the last result

    // Frame shapes the stimulus builds; all but the good one and noise break a rule.
    typedef enum int {
        FR_GOOD,
        FR_NOISE,
        FR_BAD_HDR2,
        FR_TOO_LONG,
        FR_EARLY_FOOTER,
        FR_BAD_CHECK,
        FR_BAD_FOOTER
    } t_frame_kind;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [7:0]           cfg_data;

    int   fail_count;
    int   pending_results;
    int   cycle_count;
    int   bytes_sent;
    int   send_idle_pct;
    int   recv_idle_pct;
    logic hold_go;
    t_cfg cur_cfg;          // register values the stimulus builds frames from

    fcpp_in_if  req_ch ();
    fcpp_out_if res_ch ();

    framed_command_packet_parser_core #(
        .MAX_PAYLOAD (MAX_PAYLOAD)
    ) u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .i_req       (req_ch),
        .o_res       (res_ch)
    );

    fcpp_result_checker #(
        .MAX_PAYLOAD (MAX_PAYLOAD)
    ) u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (cfg_we),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data),
        .i_req_mon    (req_ch),
        .i_res_mon    (res_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending_results)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Watchdog: a hang or a lost result ends the run here.
    initial begin
        cycle_count = 0;
        forever begin
            @(posedge i_clk);
            cycle_count++;
            if (cycle_count >= CYCLE_LIMIT) begin
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    // Result side. Random back-pressure at recv_idle_pct, plus one long
    // hold-off once hold_go is raised: the sender keeps offering bytes so
    // the output buffer fills and the request channel stalls.
    initial begin
        int   hold_left;
        logic hold_used;
        hold_left    = 0;
        hold_used    = 1'b0;
        res_ch.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_go && !hold_used) begin
                hold_used = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                res_ch.ready <= 1'b0;
            end else begin
                res_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    // One request. Random gaps first, then valid stays up until accepted.
    // Ready is sampled at the falling edge, where it is settled, so the
    // handshake seen here matches the one the block sees at the next edge.
    task automatic send_byte(input logic [7:0] b);
        logic took;
        while ($urandom_range(99) < send_idle_pct) begin
            req_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        req_ch.valid   <= 1'b1;
        req_ch.in_byte <= b;
        do begin
            @(negedge i_clk);
            took = req_ch.ready;
            @(posedge i_clk);
        end while (!took);
        bytes_sent++;
    endtask

    // Stop offering and wait until every result has come back. Every request
    // yields a result, so an empty expectation store means the block is idle.
    task automatic wait_drained();
        req_ch.valid <= 1'b0;
        do @(negedge i_clk); while (pending_results != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge i_clk);
    endtask

    // Writes all four registers on consecutive edges, enable dropped once.
    task automatic write_regs(input t_cfg s);
        put_reg(CFG_HEADER_FIRST,  s.header_first);
        put_reg(CFG_HEADER_SECOND, s.header_second);
        put_reg(CFG_FOOTER_BYTE,   s.footer_byte);
        put_reg(CFG_CHECK_BYTE,    s.check_byte);
        cfg_we  <= 1'b0;
        cur_cfg  = s;
    endtask

    // Builds one frame of the given shape from the current register values.
    // len is the length byte; for a too-long frame it is already above the
    // limit. Payload bytes other than the last never hit the footer value
    // unless an early footer is wanted.
    task automatic send_frame(input t_frame_kind kind, input logic [7:0] cmd,
                              input int len);
        logic [7:0] b;
        logic [7:0] flip;
        int         cut;
        int         i;
        flip = 8'($urandom_range(255, 1));
        if (kind == FR_NOISE) begin
            b = 8'($urandom_range(255));
            send_byte(b);
            return;
        end
        send_byte(cur_cfg.header_first);
        if (kind == FR_BAD_HDR2) begin
            send_byte(cur_cfg.header_second ^ flip);
            return;
        end
        send_byte(cur_cfg.header_second);
        send_byte(cmd);
        b = 8'(len);
        send_byte(b);
        if (kind == FR_TOO_LONG) return;
        if (len == 0) begin
            b = cur_cfg.check_byte;
            if (kind == FR_BAD_CHECK) b = b ^ flip;
            send_byte(b);
        end else begin
            cut = $urandom_range(len - 1, 0);
            for (i = 0; i <= len; i++) begin
                if (i == len) begin
                    b = cur_cfg.check_byte;
                    if (kind == FR_BAD_CHECK) b = b ^ flip;
                end else if (kind == FR_EARLY_FOOTER && i == cut) begin
                    send_byte(cur_cfg.footer_byte);
                    return;
                end else begin
                    b = 8'($urandom_range(255));
                    if (b == cur_cfg.footer_byte) b = b ^ 8'h01;
                end
                send_byte(b);
            end
        end
        b = cur_cfg.footer_byte;
        if (kind == FR_BAD_FOOTER) b = b ^ flip;
        send_byte(b);
    endtask

    // Mostly well-formed frames with random content; the rest noise and
    // frames broken in one place. Lengths are mostly short, a few reach the
    // largest payload, and too-long lengths favor the first illegal value.
    task automatic send_random_frame();
        t_frame_kind kind;
        int          r;
        int          len;
        logic [7:0]  cmd;
        r = $urandom_range(99);
        if      (r < 5)  kind = FR_NOISE;
        else if (r < 70) kind = FR_GOOD;
        else if (r < 75) kind = FR_BAD_HDR2;
        else if (r < 80) kind = FR_TOO_LONG;
        else if (r < 87) kind = FR_EARLY_FOOTER;
        else if (r < 93) kind = FR_BAD_CHECK;
        else             kind = FR_BAD_FOOTER;
        r = $urandom_range(99);
        if      (r < 60) len = $urandom_range(5, 0);
        else if (r < 90) len = $urandom_range(20, 6);
        else if (r < 97) len = $urandom_range(MAX_PAYLOAD - 2, 21);
        else             len = MAX_PAYLOAD - 1;
        if (kind == FR_TOO_LONG) begin
            len = ($urandom_range(1) == 0) ? MAX_PAYLOAD : $urandom_range(255, MAX_PAYLOAD);
        end
        if (kind == FR_EARLY_FOOTER && len == 0) len = 1;
        cmd = 8'($urandom_range(255));
        send_frame(kind, cmd, len);
    endtask

    initial begin
        t_cfg setting;
        int   start_count;
        int   k;

        // Everything the block reads is known from time zero.
        i_rst_n        = 1'b0;
        cfg_we         = 1'b0;
        cfg_index      = CFG_HEADER_FIRST;
        cfg_data       = 8'd0;
        req_ch.valid   = 1'b0;
        req_ch.in_byte = 8'd0;
        send_idle_pct  = 14;
        recv_idle_pct  = 72;
        hold_go        = 1'b0;
        bytes_sent     = 0;
        cur_cfg.header_first  = HEADER_FIRST_RST;
        cur_cfg.header_second = HEADER_SECOND_RST;
        cur_cfg.footer_byte   = FOOTER_BYTE_RST;
        cur_cfg.check_byte    = CHECK_BYTE_RST;

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed frames on the reset register values:
        // a stray byte that is not a first header is skipped,
        send_byte(8'hFF);
        // a good zero-length frame with the largest command,
        send_frame(FR_GOOD, 8'hFF, 0);
        // a second header mismatch,
        send_frame(FR_BAD_HDR2, 8'h00, 0);
        // a length of 255, which must not wrap to a zero-byte payload,
        send_frame(FR_TOO_LONG, 8'h12, 255);
        // the first length past the payload limit,
        send_frame(FR_TOO_LONG, 8'h34, MAX_PAYLOAD);
        // a footer inside a one-byte-length payload,
        send_frame(FR_EARLY_FOOTER, 8'h56, 1);
        // and a wrong separate check byte.
        send_frame(FR_BAD_CHECK, 8'h78, 0);

        // Random part in three idling phases, each on its own register
        // setting: both extremes first, then random values.
        for (k = 0; k < 3; k++) begin
            wait_drained();
            case (k)
                0: setting = '{header_first: 8'h00, header_second: 8'hFF,
                               footer_byte: 8'hFF, check_byte: 8'h00};
                1: setting = '{header_first: 8'hFF, header_second: 8'h00,
                               footer_byte: 8'h00, check_byte: 8'hFF};
                default: begin
                    setting.header_first  = 8'($urandom_range(255));
                    setting.header_second = 8'($urandom_range(255));
                    setting.footer_byte   = 8'($urandom_range(255));
                    setting.check_byte    = 8'($urandom_range(255));
                end
            endcase
            write_regs(setting);
            case (k)
                0: begin
                    send_idle_pct = 14;
                    recv_idle_pct = 72;
                end
                1: begin
                    send_idle_pct = 72;
                    recv_idle_pct = 14;
                    hold_go       = 1'b1;   // long receiver stall, sender keeps going
                end
                default: begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            start_count = bytes_sent;
            while (bytes_sent - start_count < PHASE_BYTES) send_random_frame();
        end

        wait_drained();
        repeat (10) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+rtl/core
rtl/core/fcpp_pkg.sv
rtl/core/fcpp_in_if.sv
rtl/core/fcpp_out_if.sv
rtl/core/fcpp_step.sv
rtl/core/fcpp_out_buf.sv
rtl/core/framed_command_packet_parser_core.sv
rtl/core/fcpp_checker.sv
tb/fcpp_result_checker.sv
tb/tb_framed_command_packet_parser_core.sv
